@@ rtl/core/trie_priority_keyword_matcher_defines.svh @@
// assertion macros for the trie keyword matcher
`ifndef TRIE_PRIORITY_KEYWORD_MATCHER_DEFINES_SVH
`define TRIE_PRIORITY_KEYWORD_MATCHER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TPKM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define TPKM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tpkm_pkg.sv @@
// shared constants and control types for the trie keyword matcher
`timescale 1ns / 1ps
package tpkm_pkg;
  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_DEPTH = 32;

  localparam int OP_W        = 2;
  localparam int CHAR_W      = 16;
  localparam int FLAG_W      = 16;
  localparam int LEVEL_W     = 8;
  localparam int STATUS_W    = 2;
  localparam int INFO_W      = 1 + LEVEL_W + FLAG_W;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MATCH  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STORED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd3;

  localparam logic [1:0] SEL_CURSOR = 2'd0;
  localparam logic [1:0] SEL_SEEKER = 2'd1;
  localparam logic [1:0] SEL_ROOT   = 2'd2;

  typedef struct packed {
    logic       cap;
    logic       scan_go;
    logic [1:0] scan_sel;
    logic       ins_fail;
    logic       ins_step;
    logic       ins_fin;
    logic       seek_keep;
    logic       seek_skip;
    logic       seek_end;
    logic       root_add;
    logic       consider;
    logic       longer;
    logic       srch_fin;
    logic       clear;
    logic       emit;
  } tpkm_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            last;
    logic            failed;
    logic            depth_full;
    logic            seek_more;
    logic            seek_len_full;
    logic            scan_done;
    logic            scan_hit;
    logic            out_free;
  } tpkm_sts_t;
endpackage

@@ rtl/core/tpkm_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps
module tpkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;
endmodule

@@ rtl/core/tpkm_datapath.sv @@
// datapath: trie stores, edge scanner, insert cursor, seekers and best match
`timescale 1ns / 1ps
module tpkm_datapath import tpkm_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  input  tpkm_cmd_t              cmd,
  output tpkm_sts_t              sts,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = NW + 1;
  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int SW = $clog2(MAX_DEPTH);
  localparam int EW = CHAR_W + NW;

  // captured request
  logic [OP_W-1:0]    op_r;
  logic [CHAR_W-1:0]  ch_r;
  logic               last_r;
  logic [FLAG_W-1:0]  wflag_r;
  logic [LEVEL_W-1:0] wlvl_r;

  logic [NW-1:0] cursor_r, cursor_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          failed_r, failed_nxt;
  logic [CW-1:0] nodes_used_r, nodes_used_nxt;

  logic [NW-1:0] sk_node_r [MAX_DEPTH];
  logic [DW-1:0] sk_len_r  [MAX_DEPTH];
  logic [DW-1:0] sk_count_r, sk_count_nxt;
  logic [DW-1:0] sk_i_r, sk_i_nxt;
  logic [DW-1:0] sk_kept_r, sk_kept_nxt;
  logic [DW-1:0] cand_len_r, cand_len_nxt;

  logic               bv_r, bv_nxt;
  logic [LEVEL_W-1:0] bl_r, bl_nxt;
  logic [DW-1:0]      blen_r, blen_nxt;
  logic [FLAG_W-1:0]  bf_r, bf_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [FLAG_W-1:0]   res_flag_r, res_flag_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [FLAG_W-1:0]   out_flag_r;

  logic          scan_busy_r, scan_busy_nxt;
  logic [CW-1:0] scan_j_r, scan_j_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [NW-1:0] rd_idx_r, rd_idx_nxt;
  logic [EW-1:0] want_r, want_nxt;

  logic              edge_we;
  logic [NW-1:0]     edge_addr;
  logic [EW-1:0]     edge_rdata;
  logic              info_we;
  logic [NW-1:0]     info_addr;
  logic [INFO_W-1:0] info_wdata;
  logic [INFO_W-1:0] info_rdata;

  logic          s_hit, s_issue, s_done;
  logic          nodes_full, create;
  logic [NW-1:0] parent;
  logic [DW-1:0] len_i;
  logic [NW-1:0] node_i;
  logic          term;
  logic [LEVEL_W-1:0] lvl;
  logic          better;

  assign nodes_full = !(nodes_used_r < CW'(MAX_NODES));
  assign len_i  = sk_len_r[sk_i_r[SW-1:0]];
  assign node_i = sk_node_r[sk_i_r[SW-1:0]];

  // edge scanner: one entry issued per cycle, compared in the cycle after its issue
  assign s_hit   = rd_vld_r && (edge_rdata == want_r);
  assign s_issue = !s_hit && (scan_j_r < nodes_used_r);
  assign s_done  = scan_busy_r && (s_hit || (!s_issue && !rd_vld_r));

  assign create = cmd.ins_step && !s_hit && !nodes_full;

  always_comb begin
    unique case (cmd.scan_sel)
      SEL_CURSOR: parent = cursor_r;
      SEL_SEEKER: parent = node_i;
      default:    parent = '0;
    endcase
  end

  always_comb begin
    scan_busy_nxt = scan_busy_r;
    scan_j_nxt    = scan_j_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    want_nxt      = want_r;
    if (cmd.scan_go) begin
      scan_busy_nxt = 1'b1;
      scan_j_nxt    = CW'(1);
      want_nxt      = {ch_r, parent};
    end else if (scan_busy_r) begin
      if (s_done) begin
        scan_busy_nxt = 1'b0;
      end else if (s_issue) begin
        rd_vld_nxt = 1'b1;
        rd_idx_nxt = scan_j_r[NW-1:0];
        scan_j_nxt = scan_j_r + CW'(1);
      end
    end
  end

  assign edge_we   = create;
  assign edge_addr = create ? nodes_used_r[NW-1:0] : scan_j_r[NW-1:0];

  always_comb begin
    info_we    = 1'b0;
    info_addr  = rd_idx_r;
    info_wdata = '0;
    if (create) begin
      info_we   = 1'b1;
      info_addr = nodes_used_r[NW-1:0];
    end else if (cmd.ins_fin && !failed_r && cursor_r != '0) begin
      info_we    = 1'b1;
      info_addr  = cursor_r;
      info_wdata = {1'b1, wlvl_r, wflag_r};
    end
  end

  tpkm_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .addr  (edge_addr),
    .wdata ({ch_r, cursor_r}),
    .rdata (edge_rdata)
  );

  tpkm_ram #(.WIDTH(INFO_W), .DEPTH(MAX_NODES)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .addr  (info_addr),
    .wdata (info_wdata),
    .rdata (info_rdata)
  );

  assign term = info_rdata[INFO_W-1];
  assign lvl  = info_rdata[INFO_W-2 -: LEVEL_W];
  assign better = term && (!bv_r || lvl > bl_r ||
                           (cmd.longer && lvl == bl_r && cand_len_r > blen_r));

  always_comb begin
    cursor_nxt     = cursor_r;
    depth_nxt      = depth_r;
    failed_nxt     = failed_r;
    nodes_used_nxt = nodes_used_r;
    sk_count_nxt   = sk_count_r;
    sk_i_nxt       = sk_i_r;
    sk_kept_nxt    = sk_kept_r;
    cand_len_nxt   = cand_len_r;
    bv_nxt         = bv_r;
    bl_nxt         = bl_r;
    blen_nxt       = blen_r;
    bf_nxt         = bf_r;
    res_status_nxt = res_status_r;
    res_flag_nxt   = res_flag_r;
    if (cmd.ins_fail) begin
      failed_nxt = 1'b1;
    end
    if (cmd.ins_step) begin
      if (s_hit) begin
        cursor_nxt = rd_idx_r;
        depth_nxt  = depth_r + DW'(1);
      end else if (nodes_full) begin
        failed_nxt = 1'b1;
      end else begin
        cursor_nxt     = nodes_used_r[NW-1:0];
        depth_nxt      = depth_r + DW'(1);
        nodes_used_nxt = nodes_used_r + CW'(1);
      end
    end
    if (cmd.ins_fin) begin
      res_status_nxt = (failed_r || cursor_r == '0) ? ST_REJECT : ST_STORED;
      res_flag_nxt   = '0;
      cursor_nxt     = '0;
      depth_nxt      = '0;
      failed_nxt     = 1'b0;
    end
    if (cmd.seek_keep) begin
      sk_kept_nxt  = sk_kept_r + DW'(1);
      cand_len_nxt = len_i + DW'(1);
      sk_i_nxt     = sk_i_r + DW'(1);
    end
    if (cmd.seek_skip) begin
      sk_i_nxt = sk_i_r + DW'(1);
    end
    if (cmd.seek_end) begin
      sk_count_nxt = sk_kept_r;
      sk_i_nxt     = '0;
      sk_kept_nxt  = '0;
    end
    if (cmd.root_add) begin
      cand_len_nxt = DW'(1);
      if (sk_count_r < DW'(MAX_DEPTH)) begin
        sk_count_nxt = sk_count_r + DW'(1);
      end
    end
    if (cmd.consider && better) begin
      bv_nxt   = 1'b1;
      bl_nxt   = lvl;
      blen_nxt = cand_len_r;
      bf_nxt   = info_rdata[FLAG_W-1:0];
    end
    if (cmd.srch_fin) begin
      res_status_nxt = bv_r ? ST_MATCH : ST_NONE;
      res_flag_nxt   = bv_r ? bf_r : '0;
    end
    if (cmd.srch_fin || cmd.clear) begin
      sk_count_nxt = '0;
      sk_i_nxt     = '0;
      sk_kept_nxt  = '0;
      bv_nxt       = 1'b0;
      bl_nxt       = '0;
      blen_nxt     = '0;
      bf_nxt       = '0;
    end
    if (cmd.clear) begin
      nodes_used_nxt = CW'(1);
      cursor_nxt     = '0;
      depth_nxt      = '0;
      failed_nxt     = 1'b0;
    end
  end

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r     <= '0;
      depth_r      <= '0;
      failed_r     <= 1'b0;
      nodes_used_r <= CW'(1);
      sk_count_r   <= '0;
      sk_i_r       <= '0;
      sk_kept_r    <= '0;
      bv_r         <= 1'b0;
      bl_r         <= '0;
      blen_r       <= '0;
      bf_r         <= '0;
      out_valid_r  <= 1'b0;
      scan_busy_r  <= 1'b0;
      rd_vld_r     <= 1'b0;
    end else begin
      cursor_r     <= cursor_nxt;
      depth_r      <= depth_nxt;
      failed_r     <= failed_nxt;
      nodes_used_r <= nodes_used_nxt;
      sk_count_r   <= sk_count_nxt;
      sk_i_r       <= sk_i_nxt;
      sk_kept_r    <= sk_kept_nxt;
      bv_r         <= bv_nxt;
      bl_r         <= bl_nxt;
      blen_r       <= blen_nxt;
      bf_r         <= bf_nxt;
      out_valid_r  <= out_valid_nxt;
      scan_busy_r  <= scan_busy_nxt;
      rd_vld_r     <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r    <= in_tdata[OP_W-1:0];
      ch_r    <= in_tdata[OP_W +: CHAR_W];
      last_r  <= in_tlast;
      wflag_r <= in_tdata[OP_W+CHAR_W +: FLAG_W];
      wlvl_r  <= in_tdata[OP_W+CHAR_W+FLAG_W +: LEVEL_W];
    end
    if (cmd.seek_keep) begin
      sk_node_r[sk_kept_r[SW-1:0]] <= rd_idx_r;
      sk_len_r[sk_kept_r[SW-1:0]]  <= len_i + DW'(1);
    end
    if (cmd.root_add && sk_count_r < DW'(MAX_DEPTH)) begin
      sk_node_r[sk_count_r[SW-1:0]] <= rd_idx_r;
      sk_len_r[sk_count_r[SW-1:0]]  <= DW'(1);
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_flag_r   <= res_flag_r;
    end
    cand_len_r   <= cand_len_nxt;
    res_status_r <= res_status_nxt;
    res_flag_r   <= res_flag_nxt;
    scan_j_r     <= scan_j_nxt;
    rd_idx_r     <= rd_idx_nxt;
    want_r       <= want_nxt;
  end

  assign sts.op            = op_r;
  assign sts.last          = last_r;
  assign sts.failed        = failed_r;
  assign sts.depth_full    = !(depth_r < DW'(MAX_DEPTH));
  assign sts.seek_more     = sk_i_r < sk_count_r;
  assign sts.seek_len_full = !(len_i < DW'(MAX_DEPTH));
  assign sts.scan_done     = s_done;
  assign sts.scan_hit      = s_hit;
  assign sts.out_free      = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-STATUS_W-FLAG_W){1'b0}}, out_flag_r, out_status_r};
endmodule

@@ rtl/core/tpkm_ctrl.sv @@
// controller: sequences insert, search and clear requests over the datapath
`timescale 1ns / 1ps
module tpkm_ctrl import tpkm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  tpkm_sts_t sts,
  output tpkm_cmd_t cmd
);
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_INS_CHK   = 4'd2;
  localparam logic [3:0] S_INS_SCAN  = 4'd3;
  localparam logic [3:0] S_INS_FIN   = 4'd4;
  localparam logic [3:0] S_SEEK_CHK  = 4'd5;
  localparam logic [3:0] S_SEEK_SCAN = 4'd6;
  localparam logic [3:0] S_SEEK_CONS = 4'd7;
  localparam logic [3:0] S_ROOT_SCAN = 4'd8;
  localparam logic [3:0] S_ROOT_CONS = 4'd9;
  localparam logic [3:0] S_SRCH_FIN  = 4'd10;
  localparam logic [3:0] S_EMIT      = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (sts.op == OP_INSERT) begin
          state_nxt = S_INS_CHK;
        end else if (sts.op == OP_SEARCH) begin
          state_nxt = S_SEEK_CHK;
        end else begin
          cmd.clear = (sts.op == OP_CLEAR);
          state_nxt = S_IDLE;
        end
      end
      S_INS_CHK: begin
        if (sts.failed) begin
          state_nxt = S_INS_FIN;
        end else if (sts.depth_full) begin
          cmd.ins_fail = 1'b1;
          state_nxt    = S_INS_FIN;
        end else begin
          cmd.scan_go  = 1'b1;
          cmd.scan_sel = SEL_CURSOR;
          state_nxt    = S_INS_SCAN;
        end
      end
      S_INS_SCAN: begin
        if (sts.scan_done) begin
          cmd.ins_step = 1'b1;
          state_nxt    = S_INS_FIN;
        end
      end
      S_INS_FIN: begin
        if (sts.last) begin
          cmd.ins_fin = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SEEK_CHK: begin
        if (sts.seek_more) begin
          if (sts.seek_len_full) begin
            cmd.seek_skip = 1'b1;
          end else begin
            cmd.scan_go  = 1'b1;
            cmd.scan_sel = SEL_SEEKER;
            state_nxt    = S_SEEK_SCAN;
          end
        end else begin
          cmd.seek_end = 1'b1;
          cmd.scan_go  = 1'b1;
          cmd.scan_sel = SEL_ROOT;
          state_nxt    = S_ROOT_SCAN;
        end
      end
      S_SEEK_SCAN: begin
        if (sts.scan_done) begin
          if (sts.scan_hit) begin
            cmd.seek_keep = 1'b1;
            state_nxt     = S_SEEK_CONS;
          end else begin
            cmd.seek_skip = 1'b1;
            state_nxt     = S_SEEK_CHK;
          end
        end
      end
      S_SEEK_CONS: begin
        cmd.consider = 1'b1;
        cmd.longer   = 1'b1;
        state_nxt    = S_SEEK_CHK;
      end
      S_ROOT_SCAN: begin
        if (sts.scan_done) begin
          if (sts.scan_hit) begin
            cmd.root_add = 1'b1;
            state_nxt    = S_ROOT_CONS;
          end else begin
            state_nxt = S_SRCH_FIN;
          end
        end
      end
      S_ROOT_CONS: begin
        cmd.consider = 1'b1;
        state_nxt    = S_SRCH_FIN;
      end
      S_SRCH_FIN: begin
        if (sts.last) begin
          cmd.srch_fin = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

@@ rtl/core/trie_priority_keyword_matcher.sv @@
// top level of the trie keyword matcher
`timescale 1ns / 1ps
// Keyword matcher over a trie held in two single-port RAMs (edges and node
// info). One request is handled at a time. Every trie lookup is a linear
// scan of the edge RAM, one entry a cycle over the nodes in use. Results
// wait in an output register, so a stalled result holds the block only
// when the next result is ready.
module trie_priority_keyword_matcher import tpkm_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES,
  parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // operation, character, word_flag, word_level, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status, match_flag, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);
  tpkm_cmd_t cmd;
  tpkm_sts_t sts;

  tpkm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tpkm_datapath #(.MAX_NODES(MAX_NODES), .MAX_DEPTH(MAX_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );
endmodule

@@ rtl/core/tpkm_checker.sv @@
// port-level checks for the trie keyword matcher and their bind
`timescale 1ns / 1ps
`include "trie_priority_keyword_matcher_defines.svh"
module tpkm_checker import tpkm_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);
  `TPKM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `TPKM_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "request overlap")
  `TPKM_ASSERT_NOW(a_flag_zero, out_tvalid && out_tdata[1:0] != ST_MATCH, out_tdata[17:2] == 16'd0, "flag without match")
  `TPKM_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[23:18] == 6'd0, "pad bits set")
endmodule

bind trie_priority_keyword_matcher tpkm_checker u_tpkm_checker (.*);

@@ sim/tb.sv @@
// testbench for the trie keyword matcher: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module tb;
  import tpkm_pkg::*;

  localparam int NODES = DEF_MAX_NODES;
  localparam int DEPTH = DEF_MAX_DEPTH;
  localparam int LIMIT = 8000000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [FLAG_W-1:0]  flag;
    logic [LEVEL_W-1:0] level;
  } req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [FLAG_W-1:0]   flag;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  trie_priority_keyword_matcher dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  req_t pending_q[$];
  res_t expected_q[$];
  req_t cur_req;
  int errors = 0;
  int sent = 0;
  int total = 1;
  int results_seen = 0;
  int hold_cnt = 0;
  bit hold_done = 0;
  int cycles = 0;

  // trie predictor state
  logic [INFO_W-1:0] ninfo[NODES];
  logic [CHAR_W-1:0] e_ch[NODES];
  int e_par[NODES];
  int nused, icur, idep;
  bit ifail;
  int sk_node[DEPTH], sk_len[DEPTH];
  int skcnt;
  bit bvalid;
  int blevel, blen;
  logic [FLAG_W-1:0] bflag;

  function automatic int trie_child(int p, logic [CHAR_W-1:0] c);
    for (int i = 1; i < nused; i++)
      if (e_ch[i] == c && e_par[i] == p) return i;
    return -1;
  endfunction

  function automatic void weigh_match(int nd, int len, bit longer_ok);
    int lv;
    lv = ninfo[nd][23:16];
    if (!ninfo[nd][24]) return;
    if (!bvalid || lv > blevel || (longer_ok && lv == blevel && len > blen)) begin
      bvalid = 1;
      blevel = lv;
      blen = len;
      bflag = ninfo[nd][15:0];
    end
  endfunction

  function automatic void clear_search();
    skcnt = 0; bvalid = 0; blevel = 0; blen = 0; bflag = '0;
  endfunction

  function automatic void predict_match(req_t r);
    res_t e;
    int nx, kept, len;
    e.flag = '0;
    if (r.op == OP_INSERT) begin
      if (!ifail) begin
        if (idep >= DEPTH) ifail = 1;
        else begin
          nx = trie_child(icur, r.ch);
          if (nx < 0) begin
            if (nused >= NODES) ifail = 1;
            else begin
              nx = nused;
              e_ch[nx] = r.ch;
              e_par[nx] = icur;
              ninfo[nx] = '0;
              nused++;
            end
          end
          if (!ifail) begin
            icur = nx;
            idep++;
          end
        end
      end
      if (r.last) begin
        if (ifail || icur == 0) e.status = ST_REJECT;
        else begin
          ninfo[icur] = {1'b1, r.level, r.flag};
          e.status = ST_STORED;
        end
        expected_q.insert(expected_q.size(), e);
        icur = 0; idep = 0; ifail = 0;
      end
    end else if (r.op == OP_SEARCH) begin
      kept = 0;
      for (int i = 0; i < skcnt; i++) begin
        len = sk_len[i];
        if (len < DEPTH) begin
          nx = trie_child(sk_node[i], r.ch);
          if (nx >= 0) begin
            len++;
            sk_node[kept] = nx;
            sk_len[kept] = len;
            kept++;
            weigh_match(nx, len, 1);
          end
        end
      end
      skcnt = kept;
      nx = trie_child(0, r.ch);
      if (nx >= 0) begin
        if (skcnt < DEPTH) begin
          sk_node[skcnt] = nx;
          sk_len[skcnt] = 1;
          skcnt++;
        end
        weigh_match(nx, 1, 0);
      end
      if (r.last) begin
        e.status = bvalid ? ST_MATCH : ST_NONE;
        e.flag = bvalid ? bflag : '0;
        expected_q.insert(expected_q.size(), e);
        clear_search();
      end
    end else if (r.op == OP_CLEAR) begin
      for (int i = 0; i < NODES; i++) ninfo[i][24] = 1'b0;
      nused = 1;
      icur = 0; idep = 0; ifail = 0;
      clear_search();
    end
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(99) < 85) return CHAR_W'(16'h0041 + $urandom_range(3));
    return CHAR_W'($urandom);
  endfunction

  task automatic add_req(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch, logic last,
                         logic [FLAG_W-1:0] flag, logic [LEVEL_W-1:0] level);
    req_t r;
    r.op = op; r.ch = ch; r.last = last; r.flag = flag; r.level = level;
    pending_q.insert(pending_q.size(), r);
  endtask

  // run of n characters base, base+inc, ...
  task automatic add_run(logic [OP_W-1:0] op, int n, logic [CHAR_W-1:0] base, int inc,
                         logic [FLAG_W-1:0] flag, logic [LEVEL_W-1:0] level);
    for (int k = 0; k < n; k++)
      add_req(op, CHAR_W'(base + k * inc), k == n - 1, flag, level);
  endtask

  task automatic add_random(int n, bit is_word);
    for (int k = 0; k < n; k++)
      add_req(is_word ? OP_INSERT : OP_SEARCH, pick_char(), k == n - 1,
              FLAG_W'($urandom), LEVEL_W'($urandom_range(3) == 0 ? $urandom : $urandom_range(3)));
  endtask

  function automatic int send_idle();
    if (sent < total / 3) return 34;
    if (sent < 2 * total / 3) return 74;
    return 0;
  endfunction

  function automatic int recv_idle();
    if (sent < total / 3) return 74;
    if (sent < 2 * total / 3) return 34;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_match(cur_req);
        sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle()) begin
          cur_req = pending_q.pop_front();
          in_tdata <= {6'b0, cur_req.level, cur_req.flag, cur_req.ch, cur_req.op};
          in_tlast <= cur_req.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result tdata=%h", out_tdata);
        end else begin
          e = expected_q.pop_front();
          if (out_tdata[1:0] !== e.status || out_tdata[17:2] !== e.flag ||
              out_tdata[23:18] !== 6'b0) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected status %0d flag %h, got status %0d flag %h",
                       e.status, e.flag, out_tdata[1:0], out_tdata[17:2]);
          end
        end
      end
      if (!hold_done && results_seen == 60 && hold_cnt == 0) hold_cnt = 3000;
      if (hold_cnt > 0) begin
        hold_cnt--;
        if (hold_cnt == 0) hold_done = 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= $urandom_range(99) >= recv_idle();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("trie_priority_keyword_matcher verification failed");
      $finish;
    end
  end

  initial begin
    int kind;
    for (int i = 0; i < NODES; i++) begin
      ninfo[i] = '0; e_ch[i] = '0; e_par[i] = 0;
    end
    nused = 1; icur = 0; idep = 0; ifail = 0;
    clear_search();

    // directed part
    add_req(OP_INSERT, 16'h0041, 1'b1, 16'hFFFF, 8'hFF);
    add_run(OP_INSERT, 2, 16'h0041, 1, 16'h0001, 8'hFF);
    add_req(OP_INSERT, 16'h0000, 1'b1, 16'h0000, 8'h00);
    add_req(OP_INSERT, 16'hFFFF, 1'b1, 16'h1234, 8'h07);
    add_run(OP_SEARCH, 2, 16'h0041, 1, '0, '0);
    add_run(OP_SEARCH, 3, 16'h0043, -1, '0, '0);
    add_req(OP_INSERT, 16'h0042, 1'b1, 16'h0002, 8'hFF);
    add_req(OP_INSERT, 16'h0041, 1'b1, 16'h0005, 8'h03);
    add_run(OP_SEARCH, 2, 16'h0041, 1, '0, '0);
    add_req(OP_SEARCH, 16'h0051, 1'b1, '0, '0);
    add_req(OP_UNUSED, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF);
    add_req(OP_SEARCH, 16'h0000, 1'b0, '0, '0);
    add_req(OP_SEARCH, 16'hFFFF, 1'b1, '0, '0);
    add_req(OP_SEARCH, 16'h0041, 1'b0, '0, '0);
    add_run(OP_INSERT, 2, 16'h0042, 1, 16'h00AA, 8'h09);
    add_req(OP_SEARCH, 16'h0043, 1'b1, '0, '0);
    add_req(OP_SEARCH, 16'h0041, 1'b0, '0, '0);
    add_req(OP_CLEAR, 16'h0000, 1'b0, '0, '0);
    add_req(OP_SEARCH, 16'h0042, 1'b1, '0, '0);
    add_run(OP_INSERT, DEPTH + 1, 16'h005A, 0, 16'h0BAD, 8'h01);
    add_run(OP_INSERT, DEPTH, 16'h0044, 0, 16'h0DDD, 8'h02);
    add_run(OP_SEARCH, DEPTH + 1, 16'h0044, 0, '0, '0);
    add_req(OP_CLEAR, 16'h0000, 1'b1, '0, '0);

    // random part, mostly words and texts over a small alphabet
    while (pending_q.size() < 940) begin
      kind = $urandom_range(99);
      if (kind < 40) add_random($urandom_range(1, 5), 1);
      else if (kind < 88) add_random($urandom_range(1, 8), 0);
      else if (kind < 92) add_req(OP_CLEAR, CHAR_W'($urandom), 1'($urandom_range(1)), '0, '0);
      else if (kind < 95) add_req(OP_UNUSED, CHAR_W'($urandom), 1'($urandom_range(1)),
                                  FLAG_W'($urandom), LEVEL_W'($urandom));
      else if (kind < 97) add_run(OP_INSERT, DEPTH + 1, pick_char(), 0, '1, '1);
      else begin
        add_random($urandom_range(1, 3), 0);
        add_req(OP_SEARCH, pick_char(), 1'b0, '0, '0);
        add_random(2, 1);
        add_random($urandom_range(1, 4), 0);
      end
    end

    add_req(OP_CLEAR, 16'h0000, 1'b0, '0, '0);
    add_run(OP_INSERT, 2, 16'h0041, 1, 16'h0F0F, 8'h10);
    add_run(OP_SEARCH, 3, 16'h0041, 1, '0, '0);
    total = pending_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() > 0 || in_tvalid || expected_q.size() > 0) @(posedge clk);
    repeat (40000) @(posedge clk);
    if (expected_q.size() > 0) errors++;

    if (errors == 0) begin
      $display("trie_priority_keyword_matcher verification clean");
    end else begin
      $display("trie_priority_keyword_matcher verification failed");
    end
    $finish;
  end
endmodule
